>>> rtl/smu_pkg.sv
`default_nettype none

package smu_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int VAL_W      = 32;
	localparam int OP_W       = 2;
	localparam int IN_W       = ((OP_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_W      = ((VAL_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_MERGE       = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} state_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_t;

endpackage

`default_nettype wire

>>> rtl/smu_list_mem.sv
`default_nettype none

module smu_list_mem
	import smu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [VAL_W-1:0] wr_data,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [VAL_W-1:0] rd_data_q
);

	logic [VAL_W-1:0] mem_q [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read every cycle; the registered word tracks the address of the previous cycle.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/smu_cmp.sv
`default_nettype none

module smu_cmp
	import smu_pkg::*;
(
	input  wire logic [VAL_W-1:0] x,
	input  wire logic [VAL_W-1:0] y,
	output cmp_t                  res
);

	// Signed two's complement ordering, exact bit equality.
	always_comb begin
		res.eq = (x == y);
		res.lt = ($signed(x) < $signed(y));
	end

endmodule

`default_nettype wire

>>> rtl/sorted_merge_union.sv
// Channel  | Direction | Ports                             | Contents
// s_axis   | in        | s_tvalid, s_tready, s_tdata[39:0] | op [1:0], value [33:2]
// m_axis   | out       | m_tvalid, m_tready, m_tdata[31:0] | merged_value [31:0]
//          |           | m_tlast                           | last_flag
//
// A load transfer is accepted back to back.
// A merge transfer makes the block busy until every value is emitted; the single shared
// compare unit picks one head per cycle while the output register can take a result.
// The output register frees the sequencer while the last result waits for its transfer.
// A stall on m_tready holds the sequencer in place; nothing is lost or repeated.
// arst_n clears both counts, the sequencer and the output valid; the list stores need no reset.
`default_nettype none

module sorted_merge_union
	import smu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // op [1:0], value [33:2], zero fill above
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata,   // merged_value [31:0]
	output logic                  m_tlast    // last_flag
);

	state_t state_q;
	state_t state_d;

	logic [CNT_W-1:0] cnt1_q, cnt2_q;
	logic [CNT_W-1:0] a_q, b_q, a_d, b_d;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_data_q;
	logic             out_last_q;

	logic [OP_W-1:0]  in_op;
	logic [VAL_W-1:0] in_value;
	logic             in_xfer;
	logic             wr1_en, wr2_en;
	logic             emit;

	logic [VAL_W-1:0] x_rd, y_rd;
	cmp_t             cmp;

	logic             a_rem, b_rem;
	logic [VAL_W-1:0] pick;
	logic             last_d;

	assign in_op    = s_tdata[OP_W-1:0];
	assign in_value = s_tdata[OP_W+VAL_W-1:OP_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	assign wr1_en = in_xfer && (in_op == OP_LOAD_FIRST) && (cnt1_q < CNT_W'(LIST_DEPTH));
	assign wr2_en = in_xfer && (in_op == OP_LOAD_SECOND) && (cnt2_q < CNT_W'(LIST_DEPTH));

	// The read address is the head index for the next cycle, so the registered
	// read data always holds the current head.
	smu_list_mem u_mem1 (
		.clk       (clk),
		.wr_en     (wr1_en),
		.wr_addr   (cnt1_q[IDX_W-1:0]),
		.wr_data   (in_value),
		.rd_addr   (a_d[IDX_W-1:0]),
		.rd_data_q (x_rd)
	);

	smu_list_mem u_mem2 (
		.clk       (clk),
		.wr_en     (wr2_en),
		.wr_addr   (cnt2_q[IDX_W-1:0]),
		.wr_data   (in_value),
		.rd_addr   (b_d[IDX_W-1:0]),
		.rd_data_q (y_rd)
	);

	smu_cmp u_cmp (
		.x   (x_rd),
		.y   (y_rd),
		.res (cmp)
	);

	assign a_rem = (a_q < cnt1_q);
	assign b_rem = (b_q < cnt2_q);

	// A new result may enter the output register when it is empty or being drained.
	assign emit = (state_q == ST_MERGE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		a_d     = a_q;
		b_d     = b_q;
		pick    = x_rd;
		unique case (state_q)
			ST_IDLE: begin
				a_d = '0;
				b_d = '0;
				if (in_xfer && (in_op == OP_MERGE) &&
				    ((cnt1_q != '0) || (cnt2_q != '0))) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				if (emit) begin
					if (a_rem && b_rem) begin
						if (cmp.eq) begin
							pick = x_rd;
							a_d  = a_q + CNT_W'(1);
							b_d  = b_q + CNT_W'(1);
						end else if (cmp.lt) begin
							pick = x_rd;
							a_d  = a_q + CNT_W'(1);
						end else begin
							pick = y_rd;
							b_d  = b_q + CNT_W'(1);
						end
					end else if (a_rem) begin
						pick = x_rd;
						a_d  = a_q + CNT_W'(1);
					end else begin
						pick = y_rd;
						b_d  = b_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Both lists are used up once this pick is made.
	assign last_d = (a_d >= cnt1_q) && (b_d >= cnt2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt1_q      <= '0;
			cnt2_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			a_q <= a_d;
			b_q <= b_d;
			if (wr1_en) begin
				cnt1_q <= cnt1_q + CNT_W'(1);
			end
			if (wr2_en) begin
				cnt2_q <= cnt2_q + CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit && last_d) begin
				state_q <= ST_IDLE;
				cnt1_q  <= '0;
				cnt2_q  <= '0;
			end else begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= pick;
			out_last_q <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> rtl/smu_checker.sv
`default_nettype none

module smu_checker
	import smu_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [IN_W-1:0]  s_tdata,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tlast
);

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// Mid-run, the block takes no new input.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input accepted during a merge run");

	// A run continues with no gap after a non-final transfer.
	a_nogap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a merge run");

	// The block becomes ready again only with the final result on the output.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid && m_tlast)
		else $error("ready returned without a final result");

	// The input goes busy only right after a merge transfer.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && (s_tdata[OP_W-1:0] == OP_MERGE)))
		else $error("input went busy without a merge transfer");

endmodule

bind sorted_merge_union smu_checker u_smu_checker (.*);

`default_nettype wire
